// ===== src/tse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS SNI extractor package
// Shared types and constants for the ClientHello server name extractor.
// ----------------------------------------------------------------------------
package tse_pkg;

    // Record layout constants.
    localparam logic [7:0] TSE_CT_HANDSHAKE   = 8'h16;
    localparam logic [7:0] TSE_HS_CLIENT_HELO = 8'h01;
    localparam logic [7:0] TSE_NAME_TYPE_HOST = 8'h00;
    localparam logic [5:0] TSE_HDR_BYTES      = 6'd43;
    localparam logic [5:0] TSE_MSG_TYPE_POS   = 6'd5;
    localparam logic [15:0] TSE_EXT_SNI       = 16'h0000;

    // Default depth of the step queue between parser and result stage.
    localparam int TSE_QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        VERD_FOUND   = 3'd0,
        VERD_SHORT   = 3'd1,
        VERD_NOT_HS  = 3'd2,
        VERD_NOT_CH  = 3'd3,
        VERD_NO_SNI  = 3'd4
    } tse_verdict_t;

    typedef enum logic {
        KIND_NAME    = 1'b0,
        KIND_VERDICT = 1'b1
    } tse_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } tse_in_t;

    typedef struct packed {
        tse_kind_t    result_kind;
        logic [7:0]   name_byte;
        tse_verdict_t verdict;
        logic [15:0]  name_length;
        logic         last_of_packet;
    } tse_result_t;

    // Everything one input byte produces: an optional name byte and an
    // optional verdict, the name byte always delivered first.
    typedef struct packed {
        logic         name_valid;
        logic [7:0]   name_byte;
        logic         verdict_valid;
        tse_verdict_t verdict;
        logic [15:0]  name_length;
    } tse_step_t;

endpackage

// ===== src/tls_sni_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS SNI extractor top level
// Parses a captured TLS ClientHello byte by byte and reports the server name.
// ----------------------------------------------------------------------------
// The block takes one record byte per cycle while the input is not stalled
// and returns each host name byte as it arrives, followed by one verdict
// transaction on the last byte of every packet. A result passes through the
// step queue and the output register before it reaches the result port. The
// parser feeds a queue of QUEUE_DEPTH step records; the input stalls only
// when that queue is full, which happens when the sink stalls or when an end
// byte that also carries a name byte needs two output transactions. With a sink
// that never stalls the block sustains one byte per cycle.
// ----------------------------------------------------------------------------
module tls_sni_extractor #(
    parameter int QUEUE_DEPTH = tse_pkg::TSE_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  tse_pkg::tse_in_t     byte_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output tse_pkg::tse_result_t result_data
);
    import tse_pkg::*;

    logic      push;
    tse_step_t push_data;
    logic      pop;
    logic      empty;
    logic      full;
    tse_step_t head;

    tse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .queue_full (full),
        .push       (push),
        .push_data  (push_data)
    );

    tse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .empty     (empty),
        .full      (full),
        .head      (head)
    );

    tse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// ===== src/tse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS SNI extractor parser front
// Accepts record bytes, tracks the ClientHello layout and produces one step
// record per byte that has something to report.
// ----------------------------------------------------------------------------
module tse_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  tse_pkg::tse_in_t  byte_data,
    input  logic              queue_full,
    output logic              push,
    output tse_pkg::tse_step_t push_data
);
    import tse_pkg::*;

    typedef enum logic [13:0] {
        PH_HEADER      = 14'b00000000000001,
        PH_SID_LEN     = 14'b00000000000010,
        PH_CS_HI       = 14'b00000000000100,
        PH_CS_LO       = 14'b00000000001000,
        PH_COMP_LEN    = 14'b00000000010000,
        PH_EXT_TYPE_HI = 14'b00000000100000,
        PH_EXT_TYPE_LO = 14'b00000001000000,
        PH_EXT_LEN_HI  = 14'b00000010000000,
        PH_EXT_LEN_LO  = 14'b00000100000000,
        PH_NAME_TYPE   = 14'b00001000000000,
        PH_NAME_LEN_HI = 14'b00010000000000,
        PH_NAME_LEN_LO = 14'b00100000000000,
        PH_NAME_BYTES  = 14'b01000000000000,
        PH_DONE        = 14'b10000000000000
    } tse_phase_t;

    logic [5:0]   byte_pos_reg,   byte_pos_next;
    tse_phase_t   phase_reg,      phase_next;
    logic [16:0]  skip_reg,       skip_next;
    logic [7:0]   hi_reg,         hi_next;
    logic [15:0]  ext_kind_reg,   ext_kind_next;
    logic [15:0]  ext_rem_reg,    ext_rem_next;
    logic [15:0]  name_rem_reg,   name_rem_next;
    logic [15:0]  name_total_reg, name_total_next;
    tse_verdict_t pending_reg,    pending_next;
    logic         confirmed_reg,  confirmed_next;

    logic         accept;
    logic         in_ext;
    logic [15:0]  ext_dec;
    logic [7:0]   b;
    tse_step_t    step;
    tse_verdict_t final_verdict;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !byte_stall;
    assign b          = byte_data.data_byte;
    assign ext_dec    = (ext_rem_reg != '0) ? ext_rem_reg - 16'd1 : ext_rem_reg;
    assign in_ext     = (phase_reg == PH_NAME_TYPE) || (phase_reg == PH_NAME_LEN_HI) ||
                        (phase_reg == PH_NAME_LEN_LO) || (phase_reg == PH_NAME_BYTES);

    always_comb
    begin
        byte_pos_next   = byte_pos_reg;
        phase_next      = phase_reg;
        skip_next       = skip_reg;
        hi_next         = hi_reg;
        ext_kind_next   = ext_kind_reg;
        ext_rem_next    = ext_rem_reg;
        name_rem_next   = name_rem_reg;
        name_total_next = name_total_reg;
        pending_next    = pending_reg;
        confirmed_next  = confirmed_reg;
        step            = '0;
        final_verdict   = VERD_SHORT;

        if (phase_reg == PH_HEADER)
        begin
            if (byte_pos_reg == '0)
                pending_next = (b == TSE_CT_HANDSHAKE) ? VERD_NO_SNI : VERD_NOT_HS;
            if (byte_pos_reg == TSE_MSG_TYPE_POS && pending_reg == VERD_NO_SNI &&
                b != TSE_HS_CLIENT_HELO)
                pending_next = VERD_NOT_CH;
            if (byte_pos_reg >= TSE_HDR_BYTES - 6'd1)
            begin
                byte_pos_next = TSE_HDR_BYTES;
                phase_next    = (pending_next == VERD_NO_SNI) ? PH_SID_LEN : PH_DONE;
            end
            else
            begin
                byte_pos_next = byte_pos_reg + 6'd1;
            end
        end
        else if (phase_reg == PH_DONE)
        begin
            // Parsing is over; wait for the end of the packet.
        end
        else if (skip_reg != '0)
        begin
            skip_next = skip_reg - 17'd1;
            if (in_ext)
                ext_rem_next = ext_dec;
        end
        else
        begin
            case (phase_reg)
                PH_SID_LEN:
                begin
                    skip_next  = {9'd0, b};
                    phase_next = PH_CS_HI;
                end
                PH_CS_HI:
                begin
                    hi_next    = b;
                    phase_next = PH_CS_LO;
                end
                PH_CS_LO:
                begin
                    skip_next  = {1'b0, hi_reg, b};
                    phase_next = PH_COMP_LEN;
                end
                PH_COMP_LEN:
                begin
                    // Compression methods plus the extensions length field.
                    skip_next  = {9'd0, b} + 17'd2;
                    phase_next = PH_EXT_TYPE_HI;
                end
                PH_EXT_TYPE_HI:
                begin
                    hi_next    = b;
                    phase_next = PH_EXT_TYPE_LO;
                end
                PH_EXT_TYPE_LO:
                begin
                    ext_kind_next = {hi_reg, b};
                    phase_next    = PH_EXT_LEN_HI;
                end
                PH_EXT_LEN_HI:
                begin
                    hi_next    = b;
                    phase_next = PH_EXT_LEN_LO;
                end
                PH_EXT_LEN_LO:
                begin
                    if (ext_kind_reg == TSE_EXT_SNI)
                    begin
                        ext_rem_next = {hi_reg, b};
                        // Skip the server name list length.
                        skip_next    = 17'd2;
                        phase_next   = PH_NAME_TYPE;
                    end
                    else
                    begin
                        skip_next  = {1'b0, hi_reg, b};
                        phase_next = PH_EXT_TYPE_HI;
                    end
                end
                PH_NAME_TYPE:
                begin
                    ext_rem_next = ext_dec;
                    if (b != TSE_NAME_TYPE_HOST)
                    begin
                        skip_next  = {1'b0, ext_dec};
                        phase_next = PH_EXT_TYPE_HI;
                    end
                    else
                    begin
                        phase_next = PH_NAME_LEN_HI;
                    end
                end
                PH_NAME_LEN_HI:
                begin
                    ext_rem_next = ext_dec;
                    hi_next      = b;
                    phase_next   = PH_NAME_LEN_LO;
                end
                PH_NAME_LEN_LO:
                begin
                    ext_rem_next    = ext_dec;
                    name_total_next = {hi_reg, b};
                    name_rem_next   = {hi_reg, b};
                    phase_next      = PH_NAME_BYTES;
                end
                PH_NAME_BYTES:
                begin
                    ext_rem_next = ext_dec;
                    if (name_rem_reg != '0)
                    begin
                        step.name_valid = 1'b1;
                        step.name_byte  = b;
                        name_rem_next   = name_rem_reg - 16'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        // The name counts only once both the name and its extension are whole.
        if (phase_next == PH_NAME_BYTES && name_rem_next == '0 && ext_rem_next == '0)
        begin
            confirmed_next = 1'b1;
            phase_next     = PH_DONE;
        end

        if (byte_data.end_of_packet)
        begin
            if (byte_pos_next < TSE_HDR_BYTES)
                final_verdict = VERD_SHORT;
            else if (confirmed_next)
                final_verdict = VERD_FOUND;
            else
                final_verdict = pending_next;
            step.verdict_valid = 1'b1;
            step.verdict       = final_verdict;
            step.name_length   = (final_verdict == VERD_FOUND) ? name_total_next : 16'd0;

            byte_pos_next   = '0;
            phase_next      = PH_HEADER;
            skip_next       = '0;
            hi_next         = '0;
            ext_kind_next   = '0;
            ext_rem_next    = '0;
            name_rem_next   = '0;
            name_total_next = '0;
            pending_next    = VERD_SHORT;
            confirmed_next  = 1'b0;
        end
    end

    assign push      = accept && (step.name_valid || step.verdict_valid);
    assign push_data = step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            phase_reg      <= PH_HEADER;
            skip_reg       <= '0;
            hi_reg         <= '0;
            ext_kind_reg   <= '0;
            ext_rem_reg    <= '0;
            name_rem_reg   <= '0;
            name_total_reg <= '0;
            pending_reg    <= VERD_SHORT;
            confirmed_reg  <= 1'b0;
        end
        else if (accept)
        begin
            byte_pos_reg   <= byte_pos_next;
            phase_reg      <= phase_next;
            skip_reg       <= skip_next;
            hi_reg         <= hi_next;
            ext_kind_reg   <= ext_kind_next;
            ext_rem_reg    <= ext_rem_next;
            name_rem_reg   <= name_rem_next;
            name_total_reg <= name_total_next;
            pending_reg    <= pending_next;
            confirmed_reg  <= confirmed_next;
        end
    end

    // A packet end always returns the parser to the start of a record.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_data.end_of_packet |=> phase_reg == PH_HEADER && byte_pos_reg == '0)
        else $error("parser not rewound after end of packet");

    // Once the name is confirmed, the parser must have left the name phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        confirmed_reg |-> phase_reg == PH_DONE)
        else $error("confirmed name while still parsing");

    // A found verdict needs the whole header and a name that is or becomes confirmed.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && push_data.verdict_valid && push_data.verdict == VERD_FOUND |->
            byte_pos_reg == TSE_HDR_BYTES && (confirmed_reg || phase_reg != PH_DONE))
        else $error("found verdict without a confirmed name");

endmodule

// ===== src/tse_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS SNI extractor step queue
// Small first-in first-out buffer of step records between parser and result
// stage.
// ----------------------------------------------------------------------------
module tse_queue #(
    parameter int DEPTH = tse_pkg::TSE_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tse_pkg::tse_step_t push_data,
    input  logic               pop,
    output logic               empty,
    output logic               full,
    output tse_pkg::tse_step_t head
);
    import tse_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tse_step_t     entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("step queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("step queue underflow");

endmodule

// ===== src/tse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS SNI extractor result stage
// Splits each step record into its result transactions and holds them in the
// output register until the sink takes them.
// ----------------------------------------------------------------------------
module tse_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  tse_pkg::tse_step_t   head,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output tse_pkg::tse_result_t result_data
);
    import tse_pkg::*;

    logic        out_valid_reg, out_valid_next;
    tse_result_t out_reg,       out_next;
    logic        name_sent_reg, name_sent_next;
    logic        load;

    assign load = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        name_sent_next = name_sent_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b0;
            if (!empty)
            begin
                out_valid_next = 1'b1;
                if (head.name_valid && !name_sent_reg)
                begin
                    out_next                = '0;
                    out_next.result_kind    = KIND_NAME;
                    out_next.name_byte      = head.name_byte;
                    out_next.verdict        = VERD_FOUND;
                    if (head.verdict_valid)
                        name_sent_next = 1'b1;
                    else
                        pop = 1'b1;
                end
                else
                begin
                    out_next.result_kind    = KIND_VERDICT;
                    out_next.name_byte      = 8'd0;
                    out_next.verdict        = head.verdict;
                    out_next.name_length    = head.name_length;
                    out_next.last_of_packet = 1'b1;
                    name_sent_next          = 1'b0;
                    pop                     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            name_sent_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            name_sent_reg <= name_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule
